// File: rtl/longest_bitonic_subsequence_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the longest bitonic subsequence block
// Concurrent checks that compile away when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef LONGEST_BITONIC_SUBSEQUENCE_ASSERT_SVH
`define LONGEST_BITONIC_SUBSEQUENCE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define LBS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define LBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LBS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define LBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: rtl/lbs_pkg.sv
// ----------------------------------------------------------------------------
// lbs_pkg
// Shared types for the longest bitonic subsequence block.
// ----------------------------------------------------------------------------
package lbs_pkg;

  localparam int LENGTH_W = 9;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_KEY   = 5'b00010,
    S_LOAD  = 5'b00100,
    S_SCAN  = 5'b01000,
    S_WRITE = 5'b10000
  } state_t;

  // store access controls for one cycle
  typedef struct packed {
    logic rd_en;
    logic val_we;
    logic len_we;
  } mem_ctl_t;

endpackage

// File: rtl/lbs_store.sv
// ----------------------------------------------------------------------------
// lbs_store
// Element store and per-entry {rise, fall} length store, registered read.
// ----------------------------------------------------------------------------
module lbs_store #(
  parameter int DEPTH = 256,
  parameter int VW    = 32,
  parameter int LW    = 9,
  parameter int AW    = 8
) (
  input  logic                clk,
  input  lbs_pkg::mem_ctl_t   ctl,
  input  logic [AW-1:0]       rd_addr,
  input  logic [AW-1:0]       wr_addr,
  input  logic [VW-1:0]       wr_val,
  input  logic [2*LW-1:0]     wr_len,
  output logic [VW-1:0]       rd_val,
  output logic [2*LW-1:0]     rd_len
);

  logic [VW-1:0]   val_mem [DEPTH];
  logic [2*LW-1:0] len_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.val_we) begin
      val_mem[wr_addr] <= wr_val;
    end
    if (ctl.rd_en) begin
      rd_val <= val_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.len_we) begin
      len_mem[wr_addr] <= wr_len;
    end
    if (ctl.rd_en) begin
      rd_len <= len_mem[rd_addr];
    end
  end

endmodule

// File: rtl/longest_bitonic_subsequence.sv
// ----------------------------------------------------------------------------
// longest_bitonic_subsequence
// Longest bitonic subsequence length over a loaded sequence, quadratic DP.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_value/in_last and raise start; an item is taken on a
//   clock edge with start high and busy low. Non-final items are stored
//   and busy stays low. Items past MAX_LEN are dropped and flagged on
//   out_overflow.
//   An item with in_last high closes the sequence. busy then stays high
//   while a forward and a backward pass run over the element store; each
//   pass visits every position i and scans the other side of it, one entry
//   read per cycle through the single store read port.
//   Result: out_valid pulses for one cycle with out_length and out_overflow.
//   The receiver cannot stall; the pulse coincides with busy falling, and
//   the next item may be given in that same cycle to start a new sequence.
//   Reset (rst_n low, synchronous) empties the sequence and clears the drop
//   flag; out_overflow and store contents are left as they were.
// ----------------------------------------------------------------------------
`include "longest_bitonic_subsequence_assert.svh"

module longest_bitonic_subsequence #(
  parameter int MAX_LEN     = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [VALUE_WIDTH-1:0] in_value,
  input  logic                   in_last,
  output logic                   out_valid,
  output logic [8:0]             out_length,
  output logic                   out_overflow
);

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int AW = $clog2(MAX_LEN);
  localparam int BW = LW + 1;

  lbs_pkg::state_t   state_r, state_nxt;
  lbs_pkg::mem_ctl_t ctl;

  logic [LW-1:0]          count_r, count_nxt;
  logic                   dropped_r, dropped_nxt;
  logic [BW-1:0]          best_r, best_nxt;
  logic [LW-1:0]          idx_r, idx_nxt;
  logic [LW-1:0]          j_r, j_nxt;
  logic                   pend_r, pend_nxt;
  logic                   bwd_r, bwd_nxt;
  logic [VALUE_WIDTH-1:0] key_r, key_nxt;
  logic [LW-1:0]          own_r, own_nxt;
  logic [LW-1:0]          top_r, top_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [8:0]             out_length_r, out_length_nxt;
  logic                   out_overflow_r, out_overflow_nxt;

  logic [AW-1:0]          rd_addr, wr_addr;
  logic [2*LW-1:0]        wr_len;
  logic [VALUE_WIDTH-1:0] rd_val;
  logic [2*LW-1:0]        rd_len;

  logic [LW-1:0]          scan_end;
  logic                   issue;
  logic [LW-1:0]          cand;
  logic                   hit;
  logic [LW-1:0]          new_len;
  logic [BW-1:0]          pair_sum;
  logic [BW-1:0]          len_m1;
  logic [BW+8:0]          len_ext;

  lbs_store #(
    .DEPTH (MAX_LEN),
    .VW    (VALUE_WIDTH),
    .LW    (LW),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .ctl     (ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_val  (in_value),
    .wr_len  (wr_len),
    .rd_val  (rd_val),
    .rd_len  (rd_len)
  );

  assign busy         = (state_r != lbs_pkg::S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_length   = out_length_r;
  assign out_overflow = out_overflow_r;

  // forward pass scans j < i, backward pass scans i < j < n
  assign scan_end = bwd_r ? count_r : idx_r;
  assign issue    = (j_r < scan_end);
  assign cand     = bwd_r ? rd_len[LW-1:0] : rd_len[2*LW-1:LW];
  assign hit      = pend_r && ($signed(rd_val) < $signed(key_r)) && (cand > top_r);
  assign new_len  = top_r + LW'(1);
  assign pair_sum = {1'b0, own_r} + {1'b0, new_len};
  assign wr_addr  = (state_r == lbs_pkg::S_IDLE) ? count_r[AW-1:0] : idx_r[AW-1:0];
  assign wr_len   = bwd_r ? {own_r, new_len} : {new_len, LW'(0)};

  always_comb begin
    state_nxt        = state_r;
    count_nxt        = count_r;
    dropped_nxt      = dropped_r;
    best_nxt         = best_r;
    idx_nxt          = idx_r;
    j_nxt            = j_r;
    pend_nxt         = 1'b0;
    bwd_nxt          = bwd_r;
    key_nxt          = key_r;
    own_nxt          = own_r;
    top_nxt          = top_r;
    out_valid_nxt    = 1'b0;
    out_length_nxt   = out_length_r;
    out_overflow_nxt = out_overflow_r;
    ctl              = '0;
    rd_addr          = j_r[AW-1:0];
    len_m1           = '0;
    len_ext          = '0;

    case (state_r)
      lbs_pkg::S_IDLE: begin
        if (start) begin
          if (count_r < LW'(MAX_LEN)) begin
            ctl.val_we = 1'b1;
            count_nxt  = count_r + LW'(1);
          end else begin
            dropped_nxt = 1'b1;
          end
          if (in_last) begin
            idx_nxt   = '0;
            bwd_nxt   = 1'b0;
            best_nxt  = '0;
            state_nxt = lbs_pkg::S_KEY;
          end
        end
      end
      lbs_pkg::S_KEY: begin
        ctl.rd_en = 1'b1;
        rd_addr   = idx_r[AW-1:0];
        j_nxt     = bwd_r ? (idx_r + LW'(1)) : '0;
        state_nxt = lbs_pkg::S_LOAD;
      end
      lbs_pkg::S_LOAD: begin
        key_nxt   = rd_val;
        own_nxt   = rd_len[2*LW-1:LW];
        top_nxt   = '0;
        ctl.rd_en = issue;
        pend_nxt  = issue;
        if (issue) begin
          j_nxt = j_r + LW'(1);
        end
        state_nxt = lbs_pkg::S_SCAN;
      end
      lbs_pkg::S_SCAN: begin
        if (hit) begin
          top_nxt = cand;
        end
        ctl.rd_en = issue;
        pend_nxt  = issue;
        if (issue) begin
          j_nxt = j_r + LW'(1);
        end else begin
          state_nxt = lbs_pkg::S_WRITE;
        end
      end
      lbs_pkg::S_WRITE: begin
        ctl.len_we = 1'b1;
        state_nxt  = lbs_pkg::S_KEY;
        if (!bwd_r) begin
          if ((idx_r + LW'(1)) == count_r) begin
            bwd_nxt = 1'b1;
            idx_nxt = count_r - LW'(1);
          end else begin
            idx_nxt = idx_r + LW'(1);
          end
        end else begin
          if (pair_sum > best_r) begin
            best_nxt = pair_sum;
          end
          if (idx_r == '0) begin
            len_m1           = best_nxt - BW'(1);
            len_ext          = (BW+9)'(len_m1);
            out_valid_nxt    = 1'b1;
            out_length_nxt   = len_ext[8:0];
            out_overflow_nxt = dropped_r;
            count_nxt        = '0;
            dropped_nxt      = 1'b0;
            best_nxt         = '0;
            state_nxt        = lbs_pkg::S_IDLE;
          end else begin
            idx_nxt = idx_r - LW'(1);
          end
        end
      end
      default: begin
        state_nxt = lbs_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lbs_pkg::S_IDLE;
      count_r     <= '0;
      dropped_r   <= 1'b0;
      best_r      <= '0;
      pend_r      <= 1'b0;
      bwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dropped_r   <= dropped_nxt;
      best_r      <= best_nxt;
      pend_r      <= pend_nxt;
      bwd_r       <= bwd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r          <= idx_nxt;
    j_r            <= j_nxt;
    key_r          <= key_nxt;
    own_r          <= own_nxt;
    top_r          <= top_nxt;
    out_length_r   <= out_length_nxt;
    out_overflow_r <= out_overflow_nxt;
  end

  `LBS_ASSERT_NOW(a_strobe_idle, clk, rst_n, out_valid_r, state_r == lbs_pkg::S_IDLE, "result strobe while evaluating")
  `LBS_ASSERT_NEXT(a_last_busy, clk, rst_n, start && !busy && in_last, busy, "final item did not start evaluation")
  `LBS_ASSERT_NOW(a_pend_scan, clk, rst_n, pend_r, state_r == lbs_pkg::S_SCAN, "scan read outstanding outside scan")
  `LBS_ASSERT_NOW(a_scan_bound, clk, rst_n, state_r == lbs_pkg::S_SCAN, j_r <= scan_end, "scan index past its end")
  `LBS_ASSERT_NOW(a_busy_count, clk, rst_n, busy, count_r != '0, "evaluating an empty sequence")

endmodule
